// ----- design/sorted_line_record_store_macros.svh -----
// -----------------------------------------------------------------------------
// sorted_line_record_store_macros.svh
// Assertion helpers used by the checker file of the record store.
// -----------------------------------------------------------------------------
`ifndef SORTED_LINE_RECORD_STORE_MACROS_SVH
`define SORTED_LINE_RECORD_STORE_MACROS_SVH

// Property checked on every clock outside reset.
`define SLRS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("record store check failed");

// Condition in one cycle implies a condition in the next.
`define SLRS_ASSERT_NEXT(lbl, cond, nxt) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) \
    else $error("record store check failed");

`endif

// ----- design/slrs_pkg.sv -----
// -----------------------------------------------------------------------------
// slrs_pkg
// Opcodes, status codes and controller/datapath handshake types.
// -----------------------------------------------------------------------------
package slrs_pkg;

  localparam logic [2:0] OP_STAGE = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_FIND = 3'd2;
  localparam logic [2:0] OP_READ = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  // record header: key low, key high, length
  localparam int REC_HDR = 3;

  localparam logic REG_PROGRAM_LIMIT = 1'b0;

  typedef enum logic [1:0] {RS_P0, RS_P1, RS_P2, RS_ADDR} rd_sel_t;
  typedef enum logic [1:0] {HS_LO, HS_HI, HS_LEN, HS_ZERO} hdr_sel_t;
  typedef enum logic [1:0] {RK_CODE, RK_HIT, RK_READ, RK_STORE} res_kind_t;

  typedef struct packed {
    logic      idle;
    rd_sel_t   rd_sel;
    logic      cap_lo;
    logic      cap_hi;
    logic      loc_step;
    logic      rm_start;
    logic      shift_start;
    logic      txt_start;
    logic      hdr_we;
    hdr_sel_t  hdr_sel;
    logic      used_add;
    logic      stage_clear;
    logic      res_load;
    res_kind_t res_kind;
    logic [1:0] res_code;
    logic      out_load;
  } slrs_cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic [2:0] opcode;
    logic       last;
    logic       ovf;
    logic       staged_zero;
    logic       p_lt_used;
    logic       key_eq;
    logic       key_gt;
    logic       hit;
    logic       cap_fail;
    logic       copy_done;
    logic       out_free;
  } slrs_stat_t;

endpackage

// ----- design/slrs_if.sv -----
// -----------------------------------------------------------------------------
// slrs_in_if / slrs_out_if
// Valid/ready channels for commands and results.
// -----------------------------------------------------------------------------
interface slrs_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [15:0] line_number;
  logic [7:0]  text_byte;
  logic [11:0] address;
  logic        last;

  modport source (output valid, opcode, line_number, text_byte, address, last,
                  input ready);
  modport sink (input valid, opcode, line_number, text_byte, address, last,
                output ready);
endinterface

interface slrs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [11:0] entry_address;
  logic [6:0]  text_length;
  logic [7:0]  read_data;
  logic [12:0] used_bytes;

  modport source (output valid, status, entry_address, text_length, read_data,
                  used_bytes, input ready);
  modport sink (input valid, status, entry_address, text_length, read_data,
                used_bytes, output ready);
endinterface

// ----- design/slrs_controller.sv -----
// -----------------------------------------------------------------------------
// slrs_controller
// Sequencer for locate, remove, shift, header write and text copy steps.
// -----------------------------------------------------------------------------
module slrs_controller (
  input  logic               clk,
  input  logic               rst,
  input  slrs_pkg::slrs_stat_t stat,
  output slrs_pkg::slrs_cmd_t  cmd
);
  import slrs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_COMMIT, S_LOC0, S_LOC1, S_LOC2, S_LOC3, S_LDONE,
    S_RM, S_RMW, S_SH, S_SHW, S_H0, S_H1, S_H2, S_TX, S_TXW, S_TAIL,
    S_RD1, S_RD2, S_FIN
  } state_t;

  typedef enum logic [1:0] {M_FIND, M_DEL, M_STORE} mode_t;

  state_t state, state_next;
  mode_t  mode, mode_next;

  // state and mode registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode  <= M_FIND;
    end else begin
      state <= state_next;
      mode  <= mode_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    cmd = '0;
    state_next = state;
    mode_next = mode;
    unique case (state)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (stat.in_valid) begin
          priority case (stat.opcode)
            OP_STAGE: begin
              if (stat.last) begin
                state_next = S_COMMIT;
                mode_next = M_STORE;
              end
            end
            OP_DELETE: begin
              state_next = S_LOC0;
              mode_next = M_DEL;
            end
            OP_FIND: begin
              state_next = S_LOC0;
              mode_next = M_FIND;
            end
            OP_READ: state_next = S_RD1;
            OP_CLEAR: state_next = S_FIN;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_COMMIT: begin
        if (stat.ovf) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RK_CODE;
          cmd.res_code = ST_TOO_LONG;
          cmd.stage_clear = 1'b1;
          state_next = S_FIN;
        end else if (stat.staged_zero) begin
          // empty text removes the key
          cmd.stage_clear = 1'b1;
          mode_next = M_DEL;
          state_next = S_LOC0;
        end else begin
          state_next = S_LOC0;
        end
      end
      S_LOC0: begin
        if (stat.p_lt_used) begin
          cmd.rd_sel = RS_P0;
          state_next = S_LOC1;
        end else begin
          state_next = S_LDONE;
        end
      end
      S_LOC1: begin
        cmd.rd_sel = RS_P1;
        cmd.cap_lo = 1'b1;
        state_next = S_LOC2;
      end
      S_LOC2: begin
        cmd.rd_sel = RS_P2;
        cmd.cap_hi = 1'b1;
        state_next = S_LOC3;
      end
      S_LOC3: begin
        cmd.loc_step = 1'b1;
        state_next = (stat.key_eq || stat.key_gt) ? S_LDONE : S_LOC0;
      end
      S_LDONE: begin
        unique case (mode)
          M_FIND: begin
            cmd.res_load = 1'b1;
            cmd.res_kind = stat.hit ? RK_HIT : RK_CODE;
            cmd.res_code = ST_NOT_FOUND;
            state_next = S_FIN;
          end
          M_DEL: begin
            cmd.res_load = 1'b1;
            cmd.res_kind = stat.hit ? RK_HIT : RK_CODE;
            cmd.res_code = ST_NOT_FOUND;
            state_next = stat.hit ? S_RM : S_FIN;
          end
          M_STORE: begin
            if (stat.cap_fail) begin
              cmd.res_load = 1'b1;
              cmd.res_kind = RK_CODE;
              cmd.res_code = ST_FULL;
              cmd.stage_clear = 1'b1;
              state_next = S_FIN;
            end else begin
              state_next = stat.hit ? S_RM : S_SH;
            end
          end
          default: state_next = S_FIN;
        endcase
      end
      S_RM: begin
        cmd.rm_start = 1'b1;
        state_next = S_RMW;
      end
      S_RMW: begin
        if (stat.copy_done) state_next = (mode == M_DEL) ? S_FIN : S_SH;
      end
      S_SH: begin
        cmd.shift_start = 1'b1;
        state_next = S_SHW;
      end
      S_SHW: begin
        if (stat.copy_done) state_next = S_H0;
      end
      S_H0: begin
        cmd.hdr_we = 1'b1;
        cmd.hdr_sel = HS_LO;
        state_next = S_H1;
      end
      S_H1: begin
        cmd.hdr_we = 1'b1;
        cmd.hdr_sel = HS_HI;
        state_next = S_H2;
      end
      S_H2: begin
        cmd.hdr_we = 1'b1;
        cmd.hdr_sel = HS_LEN;
        state_next = S_TX;
      end
      S_TX: begin
        cmd.txt_start = 1'b1;
        state_next = S_TXW;
      end
      S_TXW: begin
        if (stat.copy_done) state_next = S_TAIL;
      end
      S_TAIL: begin
        cmd.hdr_we = 1'b1;
        cmd.hdr_sel = HS_ZERO;
        cmd.used_add = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_kind = RK_STORE;
        cmd.stage_clear = 1'b1;
        state_next = S_FIN;
      end
      S_RD1: begin
        cmd.rd_sel = RS_ADDR;
        state_next = S_RD2;
      end
      S_RD2: begin
        cmd.res_load = 1'b1;
        cmd.res_kind = RK_READ;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- design/slrs_datapath.sv -----
// -----------------------------------------------------------------------------
// slrs_datapath
// Record memory, staging buffer, walk pointer, byte copy engine and result
// registers.
// -----------------------------------------------------------------------------
module slrs_datapath #(
  parameter int MEM_BYTES = 4096,
  parameter int LINE_BYTES = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  slrs_in_if.sink              cmd_ch,
  slrs_out_if.source           rsp_ch,
  input  logic [12:0]          limit,
  input  slrs_pkg::slrs_cmd_t  ctl,
  output slrs_pkg::slrs_stat_t stat
);
  import slrs_pkg::*;

  // offsets run past the used region by at most one record header and text
  localparam int AW = $clog2(MEM_BYTES + 260);
  localparam int MW = $clog2(MEM_BYTES);
  localparam int SW = $clog2(LINE_BYTES);

  logic [7:0] mem [MEM_BYTES];
  logic [7:0] stage_buf [LINE_BYTES];

  logic [AW-1:0] used, p, cp_src, cp_dst, cp_cnt;
  logic [SW-1:0] staged;
  logic          ovf, hit, cp_down, cp_buf, cp_pend;
  logic [15:0]   key;
  logic [11:0]   raddr;
  logic [7:0]    klo, khi, rlen, mrd, brd;
  logic [MW-1:0] cp_wa;
  logic [1:0]    res_status;
  logic [11:0]   res_ea;
  logic [6:0]    res_tl;
  logic [7:0]    res_rd;

  logic          accept, stage_we, copy_busy;
  logic [MW-1:0] mra, mwa;
  logic          mwe;
  logic [7:0]    mwd;
  logic [AW-1:0] p_1, p_2, p_adv, p_tail, nx_raw, nx, size, old, lim;
  logic [15:0]   rec_key;
  logic [31:0]   addr32, p32, used32, staged32;

  assign accept = cmd_ch.valid && ctl.idle;
  assign cmd_ch.ready = ctl.idle;

  assign rec_key = {khi, klo};
  assign p_1 = p + AW'(1);
  assign p_2 = p + AW'(2);
  assign p_adv = p + AW'(mrd) + AW'(REC_HDR + 1);
  assign p_tail = p + AW'(REC_HDR) + AW'(staged);
  assign nx_raw = p + AW'(rlen) + AW'(REC_HDR + 1);
  assign nx = (nx_raw > used) ? used : nx_raw;
  assign size = AW'(staged) + AW'(REC_HDR + 1);
  assign old = hit ? (AW'(rlen) + AW'(REC_HDR + 1)) : '0;
  assign lim = (32'(limit) < MEM_BYTES) ? AW'(limit) : AW'(MEM_BYTES);
  assign addr32 = {20'd0, raddr};
  assign p32 = 32'(p);
  assign used32 = 32'(used);
  assign staged32 = 32'(staged);
  assign copy_busy = (cp_cnt != '0);
  assign stage_we = accept && (cmd_ch.opcode == OP_STAGE) && (cmd_ch.text_byte != 8'd0)
                    && (staged != SW'(LINE_BYTES - 1));

  // status to the controller
  always_comb begin
    stat.in_valid = cmd_ch.valid;
    stat.opcode = cmd_ch.opcode;
    stat.last = cmd_ch.last;
    stat.ovf = ovf;
    stat.staged_zero = (staged == '0);
    stat.p_lt_used = (p < used);
    stat.key_eq = (rec_key == key);
    stat.key_gt = (rec_key > key);
    stat.hit = hit;
    stat.cap_fail = (used - old + size) > lim;
    stat.copy_done = !copy_busy && !cp_pend;
    stat.out_free = !rsp_ch.valid || rsp_ch.ready;
  end

  // memory read address: copy engine first, else walk or read command
  always_comb begin
    if (copy_busy) begin
      mra = cp_src[MW-1:0];
    end else begin
      unique case (ctl.rd_sel)
        RS_P0: mra = p[MW-1:0];
        RS_P1: mra = p_1[MW-1:0];
        RS_P2: mra = p_2[MW-1:0];
        RS_ADDR: mra = addr32[MW-1:0];
        default: mra = p[MW-1:0];
      endcase
    end
  end

  // memory write port: copy engine or header bytes
  always_comb begin
    mwe = 1'b0;
    mwa = p[MW-1:0];
    mwd = 8'd0;
    if (cp_pend) begin
      mwe = 1'b1;
      mwa = cp_wa;
      mwd = cp_buf ? brd : mrd;
    end else if (ctl.hdr_we) begin
      mwe = 1'b1;
      unique case (ctl.hdr_sel)
        HS_LO: begin
          mwa = p[MW-1:0];
          mwd = key[7:0];
        end
        HS_HI: begin
          mwa = p_1[MW-1:0];
          mwd = key[15:8];
        end
        HS_LEN: begin
          mwa = p_2[MW-1:0];
          mwd = 8'(staged);
        end
        HS_ZERO: begin
          mwa = p_tail[MW-1:0];
          mwd = 8'd0;
        end
        default: mwe = 1'b0;
      endcase
    end
  end

  // record memory and staging buffer
  always_ff @(posedge clk) begin
    mrd <= mem[mra];
    if (mwe) mem[mwa] <= mwd;
  end

  always_ff @(posedge clk) begin
    brd <= stage_buf[cp_src[SW-1:0]];
    if (stage_we) stage_buf[staged] <= cmd_ch.text_byte;
  end

  // byte copy engine: read one byte a cycle, write it the next
  always_ff @(posedge clk) begin
    if (rst) begin
      cp_cnt <= '0;
      cp_pend <= 1'b0;
    end else begin
      cp_pend <= copy_busy;
      cp_wa <= cp_dst[MW-1:0];
      if (ctl.rm_start) begin
        cp_src <= nx;
        cp_dst <= p;
        cp_cnt <= used - nx;
        cp_down <= 1'b0;
        cp_buf <= 1'b0;
      end else if (ctl.shift_start) begin
        cp_src <= used - AW'(1);
        cp_dst <= used - AW'(1) + size;
        cp_cnt <= used - p;
        cp_down <= 1'b1;
        cp_buf <= 1'b0;
      end else if (ctl.txt_start) begin
        cp_src <= '0;
        cp_dst <= p + AW'(REC_HDR);
        cp_cnt <= AW'(staged);
        cp_down <= 1'b0;
        cp_buf <= 1'b1;
      end else if (copy_busy) begin
        cp_src <= cp_down ? cp_src - AW'(1) : cp_src + AW'(1);
        cp_dst <= cp_down ? cp_dst - AW'(1) : cp_dst + AW'(1);
        cp_cnt <= cp_cnt - AW'(1);
      end
    end
  end

  // occupancy and staging state
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      staged <= '0;
      ovf <= 1'b0;
    end else begin
      if (accept && cmd_ch.opcode == OP_CLEAR) begin
        used <= '0;
        staged <= '0;
        ovf <= 1'b0;
      end else begin
        if (ctl.rm_start) used <= used - (nx - p);
        else if (ctl.used_add) used <= used + size;
        if (ctl.stage_clear) begin
          staged <= '0;
          ovf <= 1'b0;
        end else if (stage_we) begin
          staged <= staged + SW'(1);
        end else if (accept && cmd_ch.opcode == OP_STAGE && cmd_ch.text_byte != 8'd0) begin
          ovf <= 1'b1;
        end
      end
    end
  end

  // command fields, record walk and result
  always_ff @(posedge clk) begin
    if (accept) begin
      key <= cmd_ch.line_number;
      raddr <= cmd_ch.address;
      p <= '0;
      hit <= 1'b0;
      res_status <= ST_OK;
      res_ea <= '0;
      res_tl <= '0;
      res_rd <= '0;
    end else begin
      if (ctl.cap_lo) klo <= mrd;
      if (ctl.cap_hi) khi <= mrd;
      if (ctl.loc_step) begin
        rlen <= mrd;
        if (rec_key == key) hit <= 1'b1;
        else if (!(rec_key > key)) p <= p_adv;
      end
      if (ctl.res_load) begin
        unique case (ctl.res_kind)
          RK_CODE: begin
            res_status <= ctl.res_code;
            res_ea <= '0;
            res_tl <= '0;
            res_rd <= '0;
          end
          RK_HIT: begin
            res_status <= ST_OK;
            res_ea <= p32[11:0];
            res_tl <= rlen[6:0];
            res_rd <= '0;
          end
          RK_READ: begin
            res_status <= ST_OK;
            res_ea <= '0;
            res_tl <= '0;
            res_rd <= (addr32 < MEM_BYTES) ? mrd : 8'd0;
          end
          RK_STORE: begin
            res_status <= ST_OK;
            res_ea <= p32[11:0];
            res_tl <= staged32[6:0];
            res_rd <= '0;
          end
          default: res_status <= ST_OK;
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_ch.valid <= 1'b0;
    end else if (ctl.out_load) begin
      rsp_ch.valid <= 1'b1;
    end else if (rsp_ch.ready) begin
      rsp_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      rsp_ch.status <= res_status;
      rsp_ch.entry_address <= res_ea;
      rsp_ch.text_length <= res_tl;
      rsp_ch.read_data <= res_rd;
      rsp_ch.used_bytes <= used32[12:0];
    end
  end

endmodule

// ----- design/sorted_line_record_store.sv -----
// -----------------------------------------------------------------------------
// sorted_line_record_store
// Key-sorted packed record store with staged insert, delete, find and read.
// -----------------------------------------------------------------------------
//   channel | dir | handshake     | contents
//   cmd     | in  | valid/ready   | opcode, line_number, text_byte, address, last
//   rsp     | out | valid/ready   | status, entry_address, text_length,
//           |     |               | read_data, used_bytes
//   apb     | in  | psel/penable  | program_limit at offset 0
//
// One command at a time. Find, delete and store walk the records through the
// single memory read port; remove, insert shift and text copy then move one
// byte per cycle.
// Reset is synchronous and empties the store; memory contents are not cleared.
// A result waiting on rsp blocks only the final step of the next command.
// -----------------------------------------------------------------------------
module sorted_line_record_store #(
  parameter int MEM_BYTES = 4096,
  parameter int LINE_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  slrs_in_if.sink     cmd,
  slrs_out_if.source  rsp
);
  import slrs_pkg::*;

  logic [12:0] program_limit;
  slrs_cmd_t   ctl;
  slrs_stat_t  stat;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PROGRAM_LIMIT) ? {19'd0, program_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      program_limit <= 13'd4096;
    end else if (psel && penable && pwrite && paddr[2] == REG_PROGRAM_LIMIT) begin
      program_limit <= pwdata[12:0];
    end
  end

  slrs_controller u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (ctl)
  );

  slrs_datapath #(
    .MEM_BYTES  (MEM_BYTES),
    .LINE_BYTES (LINE_BYTES)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd_ch (cmd),
    .rsp_ch (rsp),
    .limit  (program_limit),
    .ctl    (ctl),
    .stat   (stat)
  );

endmodule

// ----- design/slrs_checker.sv -----
// -----------------------------------------------------------------------------
// slrs_checker
// Port-level checks on result transactions of the record store.
// -----------------------------------------------------------------------------
`include "sorted_line_record_store_macros.svh"

module slrs_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [11:0] entry_address,
  input logic [6:0]  text_length,
  input logic [7:0]  read_data
);
  import slrs_pkg::*;

  logic no_loc;

  // no record location carried
  assign no_loc = (entry_address == 12'd0) && (text_length == 7'd0);

  // a result stays offered until taken
  `SLRS_ASSERT_NEXT(a_rsp_hold, out_valid && !out_ready, out_valid)

  // failures carry no record location
  `SLRS_ASSERT(a_fail_empty, (out_valid && status != ST_OK) |-> (no_loc && read_data == 8'd0))

  // a read byte only comes with a read transaction
  `SLRS_ASSERT(a_read_only, (out_valid && read_data != 8'd0) |-> (status == ST_OK && no_loc))

endmodule

bind sorted_line_record_store slrs_checker u_slrs_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (rsp.valid),
  .out_ready     (rsp.ready),
  .status        (rsp.status),
  .entry_address (rsp.entry_address),
  .text_length   (rsp.text_length),
  .read_data     (rsp.read_data)
);

// ----- test/sorted_line_record_store_test.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sorted_line_record_store_test
// Self-checking bench for the key-sorted record store. A queue-fed driver sends
// commands, an in-bench model of the store predicts every response, and a
// monitor compares responses field by field. Both channels idle in random
// bursts; the limit register is rewritten between phases while the store idles.
// -----------------------------------------------------------------------------
module sorted_line_record_store_test;
  import slrs_pkg::*;

  localparam int MEM_SIZE = 4096;
  localparam int TEXT_MAX = 128;
  localparam int CYCLE_LIMIT = 20000000;

  typedef struct {
    logic [2:0]  opcode;
    logic [15:0] line_number;
    logic [7:0]  text_byte;
    logic [11:0] address;
    logic        last;
  } cmd_item_t;

  typedef struct {
    logic [1:0]  status;
    logic [11:0] entry_address;
    logic [6:0]  text_length;
    logic [7:0]  read_data;
    logic [12:0] used_bytes;
  } rsp_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  slrs_in_if cmd ();
  slrs_out_if rsp ();

  sorted_line_record_store uut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .cmd(cmd.sink), .rsp(rsp.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cmd_item_t pending_cmds[$];
  rsp_item_t expected_rsps[$];
  int errors = 0;
  bit quiet = 1'b0;
  int hold_req = 0;
  int written_top = 0;  // bytes below this offset have been written at least once

  // shadow of the store
  logic [7:0] shadow_mem[MEM_SIZE];
  int shadow_used = 0;
  logic [7:0] shadow_text[TEXT_MAX];
  int shadow_staged = 0;
  bit shadow_ovf = 1'b0;
  int shadow_limit = 4096;

  function automatic int mem_byte(int a);
    return (a < MEM_SIZE) ? int'(shadow_mem[a]) : 0;
  endfunction

  function automatic int next_record(int p);
    return p + REC_HDR + mem_byte(p + 2) + 1;
  endfunction

  // first record whose key is not below k
  function automatic int seek_key(int k, output bit hit);
    int p, key;
    p = 0;
    hit = 1'b0;
    while (p < shadow_used) begin
      key = mem_byte(p) | (mem_byte(p + 1) << 8);
      if (key == k) begin
        hit = 1'b1;
        return p;
      end
      if (key > k) return p;
      p = next_record(p);
    end
    return p;
  endfunction

  function automatic void cut_record(int p);
    int nx;
    nx = next_record(p);
    if (nx > shadow_used) nx = shadow_used;
    for (int i = 0; i < shadow_used - nx; i++) shadow_mem[p + i] = shadow_mem[nx + i];
    shadow_used -= nx - p;
  endfunction

  function automatic rsp_item_t make_rsp(int st, int ea, int tl, int rd);
    rsp_item_t r;
    r.status = st[1:0];
    r.entry_address = ea[11:0];
    r.text_length = tl[6:0];
    r.read_data = rd[7:0];
    r.used_bytes = shadow_used[12:0];
    return r;
  endfunction

  function automatic rsp_item_t delete_key(int k);
    bit hit;
    int p, len;
    p = seek_key(k, hit);
    if (!hit) return make_rsp(ST_NOT_FOUND, 0, 0, 0);
    len = mem_byte(p + 2);
    cut_record(p);
    return make_rsp(ST_OK, p, len, 0);
  endfunction

  function automatic rsp_item_t commit_line(int k);
    int len, size, lim, p, old;
    bit over, hit;
    len = shadow_staged;
    over = shadow_ovf;
    shadow_staged = 0;
    shadow_ovf = 1'b0;
    if (over) return make_rsp(ST_TOO_LONG, 0, 0, 0);
    if (len == 0) return delete_key(k);
    size = REC_HDR + len + 1;
    lim = (shadow_limit < MEM_SIZE) ? shadow_limit : MEM_SIZE;
    p = seek_key(k, hit);
    old = hit ? next_record(p) - p : 0;
    if (shadow_used - old + size > lim) return make_rsp(ST_FULL, 0, 0, 0);
    if (hit) cut_record(p);
    for (int i = shadow_used - p - 1; i >= 0; i--) shadow_mem[p + size + i] = shadow_mem[p + i];
    shadow_mem[p] = k[7:0];
    shadow_mem[p + 1] = k[15:8];
    shadow_mem[p + 2] = len[7:0];
    for (int i = 0; i < len; i++) shadow_mem[p + REC_HDR + i] = shadow_text[i];
    shadow_mem[p + REC_HDR + len] = 8'h00;
    shadow_used += size;
    if (shadow_used > written_top) written_top = shadow_used;
    return make_rsp(ST_OK, p, len, 0);
  endfunction

  // advance the shadow by one accepted command, queue its response if any
  task automatic predict_response(cmd_item_t c);
    bit hit;
    int p;
    case (c.opcode)
      OP_STAGE: begin
        if (c.text_byte != 0) begin
          if (shadow_staged < TEXT_MAX - 1) begin
            shadow_text[shadow_staged] = c.text_byte;
            shadow_staged++;
          end else begin
            shadow_ovf = 1'b1;
          end
        end
        if (c.last) expected_rsps.push_back(commit_line(int'(c.line_number)));
      end
      OP_DELETE: expected_rsps.push_back(delete_key(int'(c.line_number)));
      OP_FIND: begin
        p = seek_key(int'(c.line_number), hit);
        if (hit) expected_rsps.push_back(make_rsp(ST_OK, p, mem_byte(p + 2), 0));
        else expected_rsps.push_back(make_rsp(ST_NOT_FOUND, 0, 0, 0));
      end
      OP_READ: expected_rsps.push_back(make_rsp(ST_OK, 0, 0, mem_byte(int'(c.address))));
      OP_CLEAR: begin
        shadow_used = 0;
        shadow_staged = 0;
        shadow_ovf = 1'b0;
        expected_rsps.push_back(make_rsp(ST_OK, 0, 0, 0));
      end
      default: ;
    endcase
  endtask

  // command driver
  cmd_item_t cur_cmd;
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (cmd.valid && cmd.ready) predict_response(cur_cmd);
      if (!cmd.valid || cmd.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          cmd.valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cur_cmd = pending_cmds.pop_front();
          cmd.opcode <= cur_cmd.opcode;
          cmd.line_number <= cur_cmd.line_number;
          cmd.text_byte <= cur_cmd.text_byte;
          cmd.address <= cur_cmd.address;
          cmd.last <= cur_cmd.last;
          cmd.valid <= 1'b1;
          if (!quiet && $urandom_range(7) == 0) send_gap = $urandom_range(14, 1);
        end else begin
          cmd.valid <= 1'b0;
        end
      end
    end
  end

  // response ready: random bursts plus a requested long hold-off
  int stall_left = 0;
  int hold_seen = 0;
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        stall_left = 600;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else if (!quiet && $urandom_range(7) == 0) begin
        stall_left = $urandom_range(14, 1) - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  task automatic report(string field, int got, int want);
    $display("mismatch %s: got %0d expected %0d", field, got, want);
    errors++;
  endtask

  // response monitor
  rsp_item_t want;
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_rsps.size() == 0) begin
        report("unexpected transaction", 1, 0);
      end else begin
        want = expected_rsps.pop_front();
        if (rsp.status !== want.status) report("status", rsp.status, want.status);
        if (rsp.entry_address !== want.entry_address)
          report("entry_address", rsp.entry_address, want.entry_address);
        if (rsp.text_length !== want.text_length)
          report("text_length", rsp.text_length, want.text_length);
        if (rsp.read_data !== want.read_data) report("read_data", rsp.read_data, want.read_data);
        if (rsp.used_bytes !== want.used_bytes)
          report("used_bytes", rsp.used_bytes, want.used_bytes);
      end
    end
  end

  // watchdog
  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_cmd(logic [2:0] op, int key, int tb, int addr, bit last);
    cmd_item_t c;
    c.opcode = op;
    c.line_number = key[15:0];
    c.text_byte = tb[7:0];
    c.address = addr[11:0];
    c.last = last;
    pending_cmds.push_back(c);
  endtask

  // one line sent as len stage commands; zero_mix sprinkles unstaged zero bytes
  task automatic push_line(int key, int len, bit zero_mix);
    for (int i = 0; i < len; i++)
      push_cmd(OP_STAGE, (i == len - 1) ? key : $urandom,
               (zero_mix && $urandom_range(5) == 0) ? 0 : $urandom_range(255, 1),
               $urandom, i == len - 1);
  endtask

  task automatic push_read();
    if (written_top > 0) push_cmd(OP_READ, $urandom, $urandom, $urandom_range(written_top - 1), 0);
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || cmd.valid || expected_rsps.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_limit(int value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'(4 * REG_PROGRAM_LIMIT);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    shadow_limit = value & 32'h1FFF;
  endtask

  int key_pool[16];

  function automatic int pick_key();
    return ($urandom_range(9) < 7) ? key_pool[$urandom_range(15)] : int'($urandom_range(65535));
  endfunction

  // random mix of short lines and other commands; stops once about n commands have been queued
  task automatic random_phase(int n);
    int sent, sel, len;
    sent = 0;
    while (sent < n) begin
      while (pending_cmds.size() >= 8) @(posedge clk);
      sel = $urandom_range(99);
      if (sel < 45) begin
        len = $urandom_range(4, 1);
        push_line(pick_key(), len, $urandom_range(3) == 0);
        sent += len;
      end else begin
        if (sel < 58) push_cmd(OP_DELETE, pick_key(), $urandom, $urandom, $urandom_range(1));
        else if (sel < 73) push_cmd(OP_FIND, pick_key(), $urandom, $urandom, $urandom_range(1));
        else if (sel < 93) push_read();
        else if (sel < 96) push_cmd(OP_CLEAR, $urandom, $urandom, $urandom, $urandom_range(1));
        else push_cmd(3'($urandom_range(7, 5)), $urandom, $urandom, $urandom, $urandom_range(1));
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    cmd.valid = 1'b0;
    cmd.opcode = '0;
    cmd.line_number = '0;
    cmd.text_byte = '0;
    cmd.address = '0;
    cmd.last = 1'b0;
    rsp.ready = 1'b0;
    for (int i = 0; i < 16; i++) key_pool[i] = $urandom_range(65535);
    key_pool[0] = 0;
    key_pool[1] = 65535;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    write_limit(4096);

    // directed: empty store, key extremes, longest text, replace, overflow
    push_cmd(OP_FIND, 0, 0, 0, 0);
    push_cmd(OP_DELETE, 65535, 0, 0, 0);
    push_cmd(OP_STAGE, 0, 255, 0, 1);
    push_cmd(OP_STAGE, 0, 1, 4095, 0);
    push_cmd(OP_STAGE, 0, 8'h80, 0, 0);
    push_cmd(OP_STAGE, 65535, 8'h7F, 0, 1);
    push_line(100, 127, 0);
    push_line(100, 2, 0);
    push_line(50, 128, 0);
    push_cmd(OP_FIND, 50, 0, 0, 0);
    // zero byte inside a line is dropped
    push_cmd(OP_STAGE, 0, 0, 0, 0);
    push_cmd(OP_STAGE, 7, 9, 0, 1);
    // commit of empty text deletes the key
    push_cmd(OP_STAGE, 65535, 0, 0, 1);
    push_cmd(OP_STAGE, 12345, 0, 0, 1);
    push_cmd(OP_FIND, 100, 0, 0, 0);
    push_cmd(3'd5, 1, 1, 1, 1);
    push_cmd(3'd6, 2, 2, 2, 0);
    push_cmd(3'd7, 3, 3, 3, 1);
    wait_idle();
    for (int a = 0; a < 3; a++) push_cmd(OP_READ, 0, 0, a, 0);
    push_cmd(OP_CLEAR, 0, 0, 0, 0);
    push_cmd(OP_FIND, 100, 0, 0, 0);
    wait_idle();

    // tightest limit: every store is full
    write_limit(4);
    push_line(1, 1, 0);
    push_line(2, 2, 0);
    wait_idle();

    write_limit(200);
    random_phase(8);
    wait_idle();

    // long response hold-off while commands keep coming
    hold_req <= hold_req + 1;
    random_phase(6);
    wait_idle();

    write_limit(4095);
    quiet = 1'b1;
    random_phase(6);
    wait_idle();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
